/* rtl/skeleton_world_to_local_pose_macros.svh */
// Assertion macros shared by the block's modules.
// Each use expects clk and rst in scope.
`ifndef SKELETON_WORLD_TO_LOCAL_POSE_MACROS_SVH
`define SKELETON_WORLD_TO_LOCAL_POSE_MACROS_SVH

`ifndef SYNTHESIS

`define SWLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swlp: property failed");

`define SWLP_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("swlp: forbidden condition seen");

`else

`define SWLP_ASSERT(label, prop)

`define SWLP_NEVER(label, cond)

`endif

`endif

/* rtl/swlp_pkg.sv */
package swlp_pkg;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_PARENT_UNSEEN  = 2'd1,
    ST_COUNT_MISMATCH = 2'd2,
    ST_NO_ROOT        = 2'd3
  } status_t;

  // how the result of a joint is formed
  typedef enum logic [1:0] {
    MODE_ROOT   = 2'd0,
    MODE_CHILD  = 2'd1,
    MODE_ORPHAN = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t   mode;
    status_t status;
    logic    fend;
  } flags_t;

  localparam logic signed [5:0] PARENT_ROOT       = -6'sd1;
  localparam logic [5:0]        JOINT_COUNT_RESET = 6'd23;
  localparam logic [5:0]        ITEM_COUNT_MAX    = 6'd63;

endpackage

/* rtl/skeleton_world_to_local_pose.sv */
// Skeleton world-to-local joint pose converter.
// Input channel (in_valid / in_stall): one joint per item with its index, parent
// index (-1 for the root), world position and world rotation quaternion, and
// frame_end on the last joint of a frame. Parents must come before children.
// Output channel (out_valid / out_stall): one result per item, in order, with the
// local position, local quaternion, frame_done, status and clipped flag.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes joint_count; always
// ready, write it only while the block is idle.
// Items pass the store read (s1), product (s2) and result registers in order. One item
// per cycle while out_stall is low; the parent pose is read from a one-read, one-write store
// in the accept cycle and the quaternion products sit in their own register stage.
// When out_stall is held the result register holds and the two stages behind it
// fill; in_stall rises only once all three stages hold items.
// Reset (synchronous, rst high) empties the pipeline, clears the seen joints, the
// frame item count and the root flag, and sets joint_count to 23. The pose store
// has no reset; an entry is only used after it was written in the same frame.
module skeleton_world_to_local_pose #(
  parameter int MAX_JOINTS = 32,
  parameter int POS_BITS   = 24,
  parameter int QUAT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [4:0]                  joint_index,
  input  logic signed [5:0]           parent_joint,
  input  logic signed [POS_BITS-1:0]  pos_x,
  input  logic signed [POS_BITS-1:0]  pos_y,
  input  logic signed [POS_BITS-1:0]  pos_z,
  input  logic signed [QUAT_BITS-1:0] rot_w,
  input  logic signed [QUAT_BITS-1:0] rot_x,
  input  logic signed [QUAT_BITS-1:0] rot_y,
  input  logic signed [QUAT_BITS-1:0] rot_z,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  out_joint,
  output logic signed [POS_BITS-1:0]  local_x,
  output logic signed [POS_BITS-1:0]  local_y,
  output logic signed [POS_BITS-1:0]  local_z,
  output logic signed [QUAT_BITS-1:0] local_w,
  output logic signed [QUAT_BITS-1:0] local_qx,
  output logic signed [QUAT_BITS-1:0] local_qy,
  output logic signed [QUAT_BITS-1:0] local_qz,
  output logic                        frame_done,
  output logic [1:0]                  status,
  output logic                        clipped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [5:0]                  cfg_data
);
  import swlp_pkg::*;

  logic [5:0]               joint_count;
  logic                     s1_valid, s1_take;
  logic [4:0]               s1_joint;
  logic [3*POS_BITS-1:0]    s1_pos, s1_ppos;
  logic [4*QUAT_BITS-1:0]   s1_rot, s1_prot;
  flags_t                   s1_flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= JOINT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      joint_count <= cfg_data;
    end
  end

  swlp_store #(
    .MAX_JOINTS (MAX_JOINTS),
    .POS_BITS   (POS_BITS),
    .QUAT_BITS  (QUAT_BITS)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .joint_index  (joint_index),
    .parent_joint (parent_joint),
    .pos_in       ({pos_z, pos_y, pos_x}),
    .rot_in       ({rot_z, rot_y, rot_x, rot_w}),
    .frame_end    (frame_end),
    .joint_count  (joint_count),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_joint     (s1_joint),
    .s1_pos       (s1_pos),
    .s1_rot       (s1_rot),
    .s1_ppos      (s1_ppos),
    .s1_prot      (s1_prot),
    .s1_flags     (s1_flags)
  );

  swlp_calc #(
    .POS_BITS  (POS_BITS),
    .QUAT_BITS (QUAT_BITS)
  ) u_calc (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_take    (s1_take),
    .s1_joint   (s1_joint),
    .s1_pos     (s1_pos),
    .s1_rot     (s1_rot),
    .s1_ppos    (s1_ppos),
    .s1_prot    (s1_prot),
    .s1_flags   (s1_flags),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_joint  (out_joint),
    .local_x    (local_x),
    .local_y    (local_y),
    .local_z    (local_z),
    .local_w    (local_w),
    .local_qx   (local_qx),
    .local_qy   (local_qy),
    .local_qz   (local_qz),
    .frame_done (frame_done),
    .status     (status),
    .clipped    (clipped)
  );

endmodule

/* rtl/swlp_store.sv */
`include "skeleton_world_to_local_pose_macros.svh"

module swlp_store #(
  parameter int MAX_JOINTS = 32,
  parameter int POS_BITS   = 24,
  parameter int QUAT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [4:0]                joint_index,
  input  logic signed [5:0]         parent_joint,
  input  logic [3*POS_BITS-1:0]     pos_in,
  input  logic [4*QUAT_BITS-1:0]    rot_in,
  input  logic                      frame_end,
  input  logic [5:0]                joint_count,
  input  logic                      s1_take,
  output logic                      s1_valid,
  output logic [4:0]                s1_joint,
  output logic [3*POS_BITS-1:0]     s1_pos,
  output logic [4*QUAT_BITS-1:0]    s1_rot,
  output logic [3*POS_BITS-1:0]     s1_ppos,
  output logic [4*QUAT_BITS-1:0]    s1_prot,
  output swlp_pkg::flags_t          s1_flags
);
  import swlp_pkg::*;

  localparam int AW = $clog2(MAX_JOINTS);
  localparam int PB = 3 * POS_BITS;
  localparam int EW = 3 * POS_BITS + 4 * QUAT_BITS;

  logic [EW-1:0]         mem [MAX_JOINTS];
  logic [EW-1:0]         rd_data;
  logic [MAX_JOINTS-1:0] seen, seen_next;
  logic [5:0]            cnt, cnt_next;
  logic                  root_seen, root_seen_next;

  logic          acc;
  logic          is_root, par_in_range, jnt_in_range, parent_ok;
  logic [AW-1:0] par_addr, jnt_addr;
  logic [5:0]    cnt_item;
  logic          root_item;
  flags_t        flags_in;

  assign in_stall = s1_valid && !s1_take;
  assign acc      = in_valid && !in_stall;

  assign is_root      = (parent_joint == PARENT_ROOT);
  assign par_in_range = !parent_joint[5] && (32'(parent_joint[4:0]) < MAX_JOINTS);
  assign jnt_in_range = 32'(joint_index) < MAX_JOINTS;
  assign par_addr     = AW'(parent_joint[4:0]);
  assign jnt_addr     = AW'(joint_index);
  assign parent_ok    = par_in_range && seen[par_addr];

  // count including this item, saturating
  assign cnt_item  = (cnt == ITEM_COUNT_MAX) ? cnt : cnt + 6'd1;
  assign root_item = root_seen || is_root;

  always_comb begin
    flags_in.fend = frame_end;
    if (is_root) begin
      flags_in.mode = MODE_ROOT;
    end else if (parent_ok) begin
      flags_in.mode = MODE_CHILD;
    end else begin
      flags_in.mode = MODE_ORPHAN;
    end
    if (frame_end && (cnt_item != joint_count)) begin
      flags_in.status = ST_COUNT_MISMATCH;
    end else if (frame_end && !root_item) begin
      flags_in.status = ST_NO_ROOT;
    end else if (flags_in.mode == MODE_ORPHAN) begin
      flags_in.status = ST_PARENT_UNSEEN;
    end else begin
      flags_in.status = ST_OK;
    end
  end

  always_comb begin
    seen_next      = seen;
    cnt_next       = cnt;
    root_seen_next = root_seen;
    if (acc) begin
      if (frame_end) begin
        seen_next      = '0;
        cnt_next       = '0;
        root_seen_next = 1'b0;
      end else begin
        if (jnt_in_range) begin
          seen_next[jnt_addr] = 1'b1;
        end
        cnt_next       = cnt_item;
        root_seen_next = root_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      seen      <= '0;
      cnt       <= '0;
      root_seen <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      seen      <= seen_next;
      cnt       <= cnt_next;
      root_seen <= root_seen_next;
    end
  end

  // read comes before write, so a joint naming itself sees the older entry
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data <= mem[par_addr];
      if (jnt_in_range) begin
        mem[jnt_addr] <= {rot_in, pos_in};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_joint <= joint_index;
      s1_pos   <= pos_in;
      s1_rot   <= rot_in;
      s1_flags <= flags_in;
    end
  end

  assign s1_ppos = rd_data[PB-1:0];
  assign s1_prot = rd_data[EW-1:PB];

  `SWLP_ASSERT(a_frame_clears, acc && frame_end |=> cnt == '0 && !root_seen && seen == '0)
  `SWLP_ASSERT(a_s1_hold, s1_valid && !s1_take |=> s1_valid && $stable(s1_joint) && $stable(s1_flags))
  `SWLP_ASSERT(a_root_ok, s1_valid && s1_flags.mode == MODE_ROOT && !s1_flags.fend |-> s1_flags.status == ST_OK)

endmodule

/* rtl/swlp_calc.sv */
`include "skeleton_world_to_local_pose_macros.svh"

module swlp_calc #(
  parameter int POS_BITS  = 24,
  parameter int QUAT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s1_valid,
  output logic                        s1_take,
  input  logic [4:0]                  s1_joint,
  input  logic [3*POS_BITS-1:0]       s1_pos,
  input  logic [4*QUAT_BITS-1:0]      s1_rot,
  input  logic [3*POS_BITS-1:0]       s1_ppos,
  input  logic [4*QUAT_BITS-1:0]      s1_prot,
  input  swlp_pkg::flags_t            s1_flags,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  out_joint,
  output logic signed [POS_BITS-1:0]  local_x,
  output logic signed [POS_BITS-1:0]  local_y,
  output logic signed [POS_BITS-1:0]  local_z,
  output logic signed [QUAT_BITS-1:0] local_w,
  output logic signed [QUAT_BITS-1:0] local_qx,
  output logic signed [QUAT_BITS-1:0] local_qy,
  output logic signed [QUAT_BITS-1:0] local_qz,
  output logic                        frame_done,
  output logic [1:0]                  status,
  output logic                        clipped
);
  import swlp_pkg::*;

  localparam int P  = POS_BITS;
  localparam int Q  = QUAT_BITS;
  localparam int DW = POS_BITS + 1;
  localparam int PW = 2 * QUAT_BITS;
  localparam int SW = 2 * QUAT_BITS + 3;

  localparam logic signed [DW-1:0] PHI = DW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] PLO = DW'(-(64'sd1 <<< (POS_BITS - 1)));
  localparam logic signed [SW-1:0] QHI = SW'((64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] QLO = SW'(-(64'sd1 <<< (QUAT_BITS - 1)));
  localparam logic signed [SW-1:0] RND = SW'(64'sd1 <<< (QUAT_BITS - 2));

  function automatic logic [P:0] sat_pos(input logic signed [DW-1:0] v);
    logic [P:0] r;
    if (v > PHI) begin
      r = {1'b1, PHI[P-1:0]};
    end else if (v < PLO) begin
      r = {1'b1, PLO[P-1:0]};
    end else begin
      r = {1'b0, v[P-1:0]};
    end
    return r;
  endfunction

  function automatic logic [Q:0] sat_quat(input logic signed [SW-1:0] v);
    logic [Q:0] r;
    if (v > QHI) begin
      r = {1'b1, QHI[Q-1:0]};
    end else if (v < QLO) begin
      r = {1'b1, QLO[Q-1:0]};
    end else begin
      r = {1'b0, v[Q-1:0]};
    end
    return r;
  endfunction

  logic s2_valid, s2_en, out_en;

  logic signed [Q-1:0] pq [4];
  logic signed [Q-1:0] oq [4];
  logic signed [P-1:0] op [3];
  logic signed [P-1:0] pp [3];

  logic [4:0]            s2_joint;
  flags_t                s2_flags;
  logic [3*P-1:0]        s2_pos;
  logic [4*Q-1:0]        s2_rot;
  logic signed [DW-1:0]  s2_diff [3];
  logic signed [PW-1:0]  s2_prod [16];

  logic signed [SW-1:0]  qsum [4];
  logic signed [SW-1:0]  qrnd [4];
  logic [P:0]            psat [3];
  logic [Q:0]            qsat [4];
  logic signed [P-1:0]   lp_next [3];
  logic signed [Q-1:0]   lq_next [4];
  logic                  clip_next;

  assign out_en  = !out_valid || !out_stall;
  assign s2_en   = !s2_valid || out_en;
  assign s1_take = s2_en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pq[i] = $signed(s1_prot[i*Q +: Q]);
      oq[i] = $signed(s1_rot[i*Q +: Q]);
    end
    for (int i = 0; i < 3; i++) begin
      op[i] = $signed(s1_pos[i*P +: P]);
      pp[i] = $signed(s1_ppos[i*P +: P]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (out_en) begin
        out_valid <= s2_valid;
      end
    end
  end

  // conj(parent) * own: parent a,b,c,d against own e,f,g,h
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_joint <= s1_joint;
      s2_flags <= s1_flags;
      s2_pos   <= s1_pos;
      s2_rot   <= s1_rot;
      for (int i = 0; i < 3; i++) begin
        s2_diff[i] <= DW'(op[i]) - DW'(pp[i]);
      end
      s2_prod[0]  <= pq[0] * oq[0];
      s2_prod[1]  <= pq[1] * oq[1];
      s2_prod[2]  <= pq[2] * oq[2];
      s2_prod[3]  <= pq[3] * oq[3];
      s2_prod[4]  <= pq[0] * oq[1];
      s2_prod[5]  <= pq[1] * oq[0];
      s2_prod[6]  <= pq[2] * oq[3];
      s2_prod[7]  <= pq[3] * oq[2];
      s2_prod[8]  <= pq[0] * oq[2];
      s2_prod[9]  <= pq[1] * oq[3];
      s2_prod[10] <= pq[2] * oq[0];
      s2_prod[11] <= pq[3] * oq[1];
      s2_prod[12] <= pq[0] * oq[3];
      s2_prod[13] <= pq[1] * oq[2];
      s2_prod[14] <= pq[2] * oq[1];
      s2_prod[15] <= pq[3] * oq[0];
    end
  end

  always_comb begin
    qsum[0] = SW'(s2_prod[0]) + SW'(s2_prod[1]) + SW'(s2_prod[2]) + SW'(s2_prod[3]);
    qsum[1] = SW'(s2_prod[4]) - SW'(s2_prod[5]) - SW'(s2_prod[6]) + SW'(s2_prod[7]);
    qsum[2] = SW'(s2_prod[8]) + SW'(s2_prod[9]) - SW'(s2_prod[10]) - SW'(s2_prod[11]);
    qsum[3] = SW'(s2_prod[12]) - SW'(s2_prod[13]) + SW'(s2_prod[14]) - SW'(s2_prod[15]);
    // round to nearest, ties toward plus infinity
    for (int i = 0; i < 4; i++) begin
      qrnd[i] = (qsum[i] + RND) >>> (Q - 1);
      qsat[i] = sat_quat(qrnd[i]);
    end
    for (int i = 0; i < 3; i++) begin
      psat[i] = sat_pos(s2_diff[i]);
    end

    clip_next = 1'b0;
    case (s2_flags.mode)
      MODE_ROOT: begin
        for (int i = 0; i < 3; i++) lp_next[i] = $signed(s2_pos[i*P +: P]);
        for (int i = 0; i < 4; i++) lq_next[i] = $signed(s2_rot[i*Q +: Q]);
      end
      MODE_CHILD: begin
        for (int i = 0; i < 3; i++) begin
          lp_next[i] = $signed(psat[i][P-1:0]);
          clip_next  = clip_next | psat[i][P];
        end
        for (int i = 0; i < 4; i++) begin
          lq_next[i] = $signed(qsat[i][Q-1:0]);
          clip_next  = clip_next | qsat[i][Q];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) lp_next[i] = '0;
        for (int i = 0; i < 4; i++) lq_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_joint  <= s2_joint;
      local_x    <= lp_next[0];
      local_y    <= lp_next[1];
      local_z    <= lp_next[2];
      local_w    <= lq_next[0];
      local_qx   <= lq_next[1];
      local_qy   <= lq_next[2];
      local_qz   <= lq_next[3];
      frame_done <= s2_flags.fend;
      status     <= s2_flags.status;
      clipped    <= clip_next;
    end
  end

  `SWLP_ASSERT(a_orphan_zero, out_valid && status == ST_PARENT_UNSEEN |-> local_x == '0 && local_w == '0 && local_qz == '0)
  `SWLP_NEVER(a_orphan_clip, out_valid && clipped && status == ST_PARENT_UNSEEN)
  `SWLP_ASSERT(a_end_status, out_valid && !frame_done |-> status != ST_COUNT_MISMATCH && status != ST_NO_ROOT)
  `SWLP_ASSERT(a_s2_kept, s2_valid && !s2_en |=> s2_valid && $stable(s2_joint) && $stable(s2_flags))

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import swlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 57;
  localparam longint POS_MAX    = 64'sd8388607;
  localparam longint POS_MIN    = -64'sd8388608;
  localparam longint QUAT_MAX   = 64'sd32767;
  localparam longint QUAT_MIN   = -64'sd32768;

  typedef struct packed {
    logic [4:0]         idx;
    logic signed [5:0]  parent;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               fend;
  } joint_t;

  typedef struct packed {
    logic [4:0]         joint;
    logic signed [23:0] lx;
    logic signed [23:0] ly;
    logic signed [23:0] lz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               fdone;
    status_t            st;
    logic               clip;
  } pose_res_t;

  typedef struct {
    int        cfg;   // joint_count to write before the item, -1 for none
    joint_t    j;
    bit        typed;
    pose_res_t want;
  } row_t;

  localparam pose_res_t NO_WANT = '{5'd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0,
                                    16'sd0, 1'b0, ST_OK, 1'b0};

  // directed part: extremes, unseen/self/out-of-range parents, frame-end errors, rounding ties
  row_t dir_tab [16] = '{
    '{-1, '{5'd0, PARENT_ROOT, 24'sh7FFFFF, 24'sh800000, 24'sd0, 16'sh7FFF, 16'sh8000,
            16'sd0, 16'sd1, 1'b1},
      1, '{5'd0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1,
           1'b1, ST_COUNT_MISMATCH, 1'b0}},
    '{4, '{5'd0, PARENT_ROOT, 24'sh800000, 24'sh7FFFFF, 24'sd0, 16'sh8000, 16'sh8000,
           16'sh8000, 16'sh8000, 1'b0},
      1, '{5'd0, 24'sh800000, 24'sh7FFFFF, 24'sd0, 16'sh8000, 16'sh8000, 16'sh8000,
           16'sh8000, 1'b0, ST_OK, 1'b0}},
    '{-1, '{5'd1, 6'sd0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh8000, 1'b0},
      1, '{5'd1, 24'sh7FFFFF, 24'sh800000, 24'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_OK, 1'b1}},
    '{-1, '{5'd2, 6'sd5, 24'sd1, 24'sd2, 24'sd3, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0},
      1, '{5'd2, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_PARENT_UNSEEN, 1'b0}},
    '{-1, '{5'd3, 6'sd3, -24'sd1, -24'sd2, -24'sd3, -16'sd1, -16'sd2, -16'sd3, -16'sd4,
            1'b1},
      1, '{5'd3, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b1, ST_PARENT_UNSEEN, 1'b0}},
    '{-1, '{5'd0, -6'sd2, 24'sd100, 24'sd100, 24'sd100, 16'sd1000, 16'sd0, 16'sd0, 16'sd0,
            1'b0},
      1, '{5'd0, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_PARENT_UNSEEN, 1'b0}},
    '{-1, '{5'd1, -6'sd32, 24'sd5, 24'sd6, 24'sd7, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 1'b0},
      1, '{5'd1, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_PARENT_UNSEEN, 1'b0}},
    '{-1, '{5'd2, 6'sd31, 24'sd8, 24'sd9, 24'sd10, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 1'b0},
      1, '{5'd2, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_PARENT_UNSEEN, 1'b0}},
    '{-1, '{5'd3, 6'sd0, 24'sd50, -24'sd50, 24'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 1'b1},
      0, NO_WANT},
    '{1, '{5'd31, PARENT_ROOT, 24'sd12345, -24'sd54321, 24'sd7, 16'sd23170, -16'sd23170,
           16'sd0, 16'sd0, 1'b1},
      1, '{5'd31, 24'sd12345, -24'sd54321, 24'sd7, 16'sd23170, -16'sd23170, 16'sd0, 16'sd0,
           1'b1, ST_OK, 1'b0}},
    '{-1, '{5'd5, 6'sd2, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
      1, '{5'd5, 24'sd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
           1'b1, ST_NO_ROOT, 1'b0}},
    '{32, '{5'd0, PARENT_ROOT, 24'sd256, 24'sd512, -24'sd768, 16'sd16384, 16'sd0, 16'sd0,
            16'sd0, 1'b0},
      1, '{5'd0, 24'sd256, 24'sd512, -24'sd768, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
           1'b0, ST_OK, 1'b0}},
    // half-way products: ties go toward plus infinity
    '{-1, '{5'd1, 6'sd0, 24'sd1280, 24'sd0, -24'sd256, 16'sd1, -16'sd1, 16'sd3, -16'sd3,
            1'b0},
      1, '{5'd1, 24'sd1024, -24'sd512, 24'sd512, 16'sd1, 16'sd0, 16'sd2, -16'sd1,
           1'b0, ST_OK, 1'b0}},
    '{-1, '{5'd1, 6'sd0, 24'sh800000, 24'sh7FFFFF, 24'sd12, 16'sd0, 16'sd0, 16'sh7FFF,
            16'sd0, 1'b0},
      0, NO_WANT},
    '{-1, '{5'd2, 6'sd1, 24'sd77, -24'sd77, 24'sd9999, 16'sd12000, -16'sd5000, 16'sd3,
            -16'sd16384, 1'b0},
      0, NO_WANT},
    '{-1, '{5'd3, 6'sd2, 24'sd0, 24'sd0, 24'sd0, 16'sh8000, 16'sh7FFF, -16'sd1, 16'sd1,
            1'b1},
      0, NO_WANT}
  };

  int phase_jc [7] = '{32, 1, 23, 12, 0, 7, 0};  // 0 picks a random count

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [4:0]          joint_index  = '0;
  logic signed [5:0]   parent_joint = '0;
  logic signed [23:0]  pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0]  rot_w = '0, rot_x = '0, rot_y = '0, rot_z = '0;
  logic                frame_end    = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [4:0]          out_joint;
  logic signed [23:0]  local_x, local_y, local_z;
  logic signed [15:0]  local_w, local_qx, local_qy, local_qz;
  logic                frame_done;
  logic [1:0]          status;
  logic                clipped;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [5:0]          cfg_data  = '0;

  // predictor state
  logic signed [23:0] world_pos [32][3];
  logic signed [15:0] world_rot [32][4];
  logic [31:0]        seen_joints     = '0;
  logic [5:0]         frame_items     = '0;
  bit                 frame_has_root  = 1'b0;
  logic [5:0]         joint_count_set = JOINT_COUNT_RESET;

  pose_res_t pose_due [$];
  pose_res_t res_head;
  int        fail_count  = 0;
  int        items_sent  = 0;
  int        idle_cycles = 0;
  bit        calm        = 1'b0;

  skeleton_world_to_local_pose u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .joint_index  (joint_index),
    .parent_joint (parent_joint),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .rot_w        (rot_w),
    .rot_x        (rot_x),
    .rot_y        (rot_y),
    .rot_z        (rot_z),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_joint    (out_joint),
    .local_x      (local_x),
    .local_y      (local_y),
    .local_z      (local_z),
    .local_w      (local_w),
    .local_qx     (local_qx),
    .local_qy     (local_qy),
    .local_qz     (local_qz),
    .frame_done   (frame_done),
    .status       (status),
    .clipped      (clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [23:0] clamp_pos(longint v, inout bit clip);
    if (v > POS_MAX) begin
      clip = 1'b1;
      return 24'sh7FFFFF;
    end
    if (v < POS_MIN) begin
      clip = 1'b1;
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  // exact four-product sum, /2^15 rounded half up, then saturated
  function automatic logic signed [15:0] quat_term(longint s, inout bit clip);
    longint r;
    r = (s + 64'sd16384) >>> 15;
    if (r > QUAT_MAX) begin
      clip = 1'b1;
      return 16'sh7FFF;
    end
    if (r < QUAT_MIN) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic pose_res_t local_pose_of(joint_t j);
    pose_res_t r;
    bit clip;
    int p;
    longint a, b, c, d, e, f, g, h;
    clip    = 1'b0;
    r       = NO_WANT;
    r.joint = j.idx;
    r.fdone = j.fend;
    p       = int'($signed(j.parent));
    if ($signed(j.parent) == PARENT_ROOT) begin
      frame_has_root = 1'b1;
      r.lx = j.px;
      r.ly = j.py;
      r.lz = j.pz;
      r.qw = j.qw;
      r.qx = j.qx;
      r.qy = j.qy;
      r.qz = j.qz;
    end else if (p >= 0 && seen_joints[p]) begin
      a = world_rot[p][0];
      b = world_rot[p][1];
      c = world_rot[p][2];
      d = world_rot[p][3];
      e = $signed(j.qw);
      f = $signed(j.qx);
      g = $signed(j.qy);
      h = $signed(j.qz);
      r.lx = clamp_pos(longint'($signed(j.px)) - world_pos[p][0], clip);
      r.ly = clamp_pos(longint'($signed(j.py)) - world_pos[p][1], clip);
      r.lz = clamp_pos(longint'($signed(j.pz)) - world_pos[p][2], clip);
      // conj(parent) * own
      r.qw = quat_term(a * e + b * f + c * g + d * h, clip);
      r.qx = quat_term(a * f - b * e - c * h + d * g, clip);
      r.qy = quat_term(a * g + b * h - c * e - d * f, clip);
      r.qz = quat_term(a * h - b * g + c * f - d * e, clip);
    end else begin
      r.st = ST_PARENT_UNSEEN;
    end
    // own pose stored after the parent read, so a self parent sees only an earlier entry of the frame
    world_pos[j.idx][0] = j.px;
    world_pos[j.idx][1] = j.py;
    world_pos[j.idx][2] = j.pz;
    world_rot[j.idx][0] = j.qw;
    world_rot[j.idx][1] = j.qx;
    world_rot[j.idx][2] = j.qy;
    world_rot[j.idx][3] = j.qz;
    seen_joints[j.idx]  = 1'b1;
    if (frame_items != ITEM_COUNT_MAX)
      frame_items = frame_items + 6'd1;
    if (j.fend) begin
      if (frame_items != joint_count_set)
        r.st = ST_COUNT_MISMATCH;
      else if (!frame_has_root)
        r.st = ST_NO_ROOT;
      seen_joints    = '0;
      frame_items    = '0;
      frame_has_root = 1'b0;
    end
    r.clip = clip;
    return r;
  endfunction

  function automatic logic signed [23:0] rand_pos();
    case ($urandom_range(7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2, 3:    return 24'($urandom_range(8191)) - 24'sd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom_range(4095)) - 16'sd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic joint_t rand_pose(logic [4:0] idx);
    joint_t j;
    j.idx    = idx;
    j.parent = PARENT_ROOT;
    j.px     = rand_pos();
    j.py     = rand_pos();
    j.pz     = rand_pos();
    j.qw     = rand_quat();
    j.qx     = rand_quat();
    j.qy     = rand_quat();
    j.qz     = rand_quat();
    j.fend   = 1'b0;
    return j;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] e,
                                      logic signed [31:0] g);
    if (e !== g) begin
      $error("%s: expected %0d, got %0d", name, e, g);
      fail_count++;
    end
  endfunction

  task automatic send_joint(joint_t j, bit typed, pose_res_t want);
    pose_res_t predicted;
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    joint_index  <= j.idx;
    parent_joint <= j.parent;
    pos_x        <= j.px;
    pos_y        <= j.py;
    pos_z        <= j.pz;
    rot_w        <= j.qw;
    rot_x        <= j.qx;
    rot_y        <= j.qy;
    rot_z        <= j.qz;
    frame_end    <= j.fend;
    do @(posedge clk); while (in_stall);
    predicted = local_pose_of(j);
    pose_due.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pose_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_joint_count(logic [5:0] n);
    drain_results();
    repeat (4) @(posedge clk);  // idle margin after the drain
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid       <= 1'b0;
    joint_count_set  = n;
  endtask

  // parents always earlier in the frame, root first
  task automatic send_good_frame(int n);
    logic [4:0] order [32];
    logic [4:0] t;
    joint_t j;
    int k, s;
    for (k = 0; k < 32; k++) order[k] = 5'(k);
    if ($urandom_range(1)) begin
      for (k = 31; k > 0; k--) begin
        s        = $urandom_range(k);
        t        = order[k];
        order[k] = order[s];
        order[s] = t;
      end
    end
    for (k = 0; k < n; k++) begin
      j = rand_pose(order[k]);
      if (k != 0) j.parent = {1'b0, order[$urandom_range(k - 1)]};
      j.fend = (k == n - 1);
      send_joint(j, 1'b0, NO_WANT);
    end
  endtask

  // random indices and parents: missing root, unseen and self parents, repeats
  task automatic send_rough_frame(int len);
    logic [4:0] prev [$];
    joint_t j;
    int k;
    for (k = 0; k < len; k++) begin
      j = rand_pose(5'($urandom));
      case ($urandom_range(4))
        0: j.parent = PARENT_ROOT;
        1: j.parent = 6'($urandom);
        2: j.parent = {1'b0, j.idx};
        default: begin
          if (prev.size() != 0) j.parent = {1'b0, prev[$urandom_range(prev.size() - 1)]};
          else j.parent = 6'($urandom);
        end
      endcase
      j.fend = (k == len - 1);
      prev.push_back(j.idx);
      send_joint(j, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pose_due.size() == 0) begin
        $error("result for joint %0d with no item pending", out_joint);
        fail_count++;
      end else begin
        res_head = pose_due.pop_front();
        check_field("out_joint", res_head.joint, out_joint);
        check_field("local_x", res_head.lx, local_x);
        check_field("local_y", res_head.ly, local_y);
        check_field("local_z", res_head.lz, local_z);
        check_field("local_w", res_head.qw, local_w);
        check_field("local_qx", res_head.qx, local_qx);
        check_field("local_qy", res_head.qy, local_qy);
        check_field("local_qz", res_head.qz, local_qz);
        check_field("frame_done", res_head.fdone, frame_done);
        check_field("status", res_head.st, status);
        check_field("clipped", res_head.clip, clipped);
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** skeleton_world_to_local_pose: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph, stop_at;
    bit paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg >= 0) set_joint_count(dir_tab[i].cfg[5:0]);
      send_joint(dir_tab[i].j, dir_tab[i].typed, dir_tab[i].want);
    end

    for (ph = 0; ph < 7; ph++) begin
      drain_results();
      calm = (ph == 2);
      set_joint_count(phase_jc[ph] != 0 ? 6'(phase_jc[ph]) : 6'($urandom_range(31, 2)));
      stop_at = items_sent + PHASE_ITEMS;
      // more than 63 items in one frame: the item counter sticks at its top
      if (ph == 3) send_rough_frame(66);
      while (items_sent < stop_at) begin
        if (ph == 4 && !paused && items_sent > stop_at - 30) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(9) < 7)
          send_good_frame(joint_count_set);
        else
          send_rough_frame($urandom_range(1) ? int'(joint_count_set) : $urandom_range(40, 1));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("** skeleton_world_to_local_pose: PASSED **");
    else
      $display("** skeleton_world_to_local_pose: FAILED **");
    $finish;
  end

endmodule
